@@ src/b64_pkg.sv @@
package b64_pkg;

	localparam int SLOTS = 4;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;	// '='
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;	// '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2F;	// '/'
	localparam logic [5:0] SEXTET_MAX = 6'd63;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Results of one input item, handed from the core to the output buffer
	typedef struct packed {
		logic [SLOTS-1:0][7:0] values;
		logic [2:0]            cnt;
		logic                  last;
	} b64_burst_t;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26)
			c = 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			c = 8'h61 + {2'b00, v - 6'd26};
		else if (v < 6'd62)
			c = 8'h30 + {2'b00, v - 6'd52};
		else if (v == 6'd62)
			c = CHAR_PLUS;
		else
			c = CHAR_SLASH;
		return c;
	endfunction

	// Anything outside the alphabet (pad included) maps to zero
	function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A)
			d = c - 8'h41;
		else if (c >= 8'h61 && c <= 8'h7A)
			d = c - 8'h61 + 8'd26;
		else if (c >= 8'h30 && c <= 8'h39)
			d = c - 8'h30 + 8'd52;
		else if (c == CHAR_PLUS)
			d = 8'd62;
		else if (c == CHAR_SLASH)
			d = {2'b00, SEXTET_MAX};
		return d[5:0];
	endfunction

endpackage

@@ src/b64_ifs.sv @@
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_value;
	logic       in_last;

	modport source (output valid, output in_value, output in_last, input ready);
	modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_value;
	logic       out_last;

	modport source (output valid, output out_value, output out_last, input ready);
	modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

interface b64_cfg_if;
	logic valid;
	logic ready;
	logic direction;

	modport source (output valid, output direction, input ready);
	modport sink   (input valid, input direction, output ready);
endinterface

@@ src/b64_core.sv @@
module b64_core (
	input  logic                clk,
	input  logic                arst_n,
	b64_in_if.sink              in_ch,
	b64_cfg_if.sink             cfg,
	input  logic                buf_free,
	output logic                load,
	output b64_pkg::b64_burst_t burst
);
	import b64_pkg::*;

	// input register
	logic       v_s1;
	logic [7:0] value_s1;
	logic       last_s1;

	// stream state
	logic        dir_q;
	logic [17:0] acc_q;
	logic [1:0]  pbc_q;
	logic [1:0]  gp_q;
	logic [1:0]  pad_q;

	logic [17:0] acc_d;
	logic [1:0]  pbc_d;
	logic [1:0]  gp_d;
	logic [1:0]  pad_d;

	// encode path
	logic [11:0] x12;
	logic [5:0]  c0, c1, fl_sx;
	logic [1:0]  k;
	logic [3:0]  rem;
	logic [1:0]  e_pbc;
	logic        flush;
	logic [1:0]  gpk, gpf, pads_e;
	logic [7:0]  fch;
	b64_burst_t  enc_b;

	// decode path
	logic        is_pad;
	logic [1:0]  padn;
	logic [23:0] full, shifted;
	logic [2:0]  pos;
	logic [2:0]  pads_d;
	logic        done;
	b64_burst_t  dec_b;

	assign load        = v_s1 && buf_free;
	assign in_ch.ready = !v_s1 || buf_free;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			value_s1 <= in_ch.in_value;
			last_s1  <= in_ch.in_last;
		end
	end

	// encode: leftover bits + byte -> 1 or 2 sextets; last: flush, pads
	always_comb begin
		x12 = {acc_q[3:0], value_s1};
		c1  = 6'd0;
		case (pbc_q)
			2'd0: begin
				c0 = x12[7:2]; k = 2'd1; rem = {2'b00, x12[1:0]}; e_pbc = 2'd1;
			end
			2'd1: begin
				c0 = x12[9:4]; k = 2'd1; rem = x12[3:0]; e_pbc = 2'd2;
			end
			2'd2: begin
				c0 = x12[11:6]; c1 = x12[5:0]; k = 2'd2; rem = 4'd0; e_pbc = 2'd0;
			end
			default: begin
				c0 = {2'b00, x12[11:8]}; c1 = x12[7:2]; k = 2'd2;
				rem = {2'b00, x12[1:0]}; e_pbc = 2'd1;
			end
		endcase
		flush  = last_s1 && (e_pbc != 2'd0);
		fl_sx  = (e_pbc == 2'd1) ? {rem[1:0], 4'b0000} : {rem, 2'b00};
		fch    = sextet_to_char(fl_sx);
		gpk    = gp_q + k;
		gpf    = gpk + {1'b0, flush};
		pads_e = 2'd0 - gpf;

		enc_b.values[0] = sextet_to_char(c0);
		enc_b.values[1] = (k == 2'd2) ? sextet_to_char(c1) : (flush ? fch : CHAR_PAD);
		enc_b.values[2] = (k == 2'd2 && flush) ? fch : CHAR_PAD;
		enc_b.values[3] = CHAR_PAD;
		enc_b.cnt  = last_s1 ? ({1'b0, k} + {2'b00, flush} + {1'b0, pads_e})
		                     : {1'b0, k};
		enc_b.last = last_s1;
	end

	// decode: collect sextets, release bytes at group end or message end
	always_comb begin
		is_pad  = (value_s1 == CHAR_PAD);
		padn    = pad_q + {1'b0, (gp_q >= 2'd2) && is_pad};
		full    = {acc_q, char_to_sextet(value_s1)};
		pos     = {1'b0, gp_q} + 3'd1;
		done    = (pos == 3'd4) || last_s1;
		case (pos)
			3'd1:    shifted = {full[5:0], 18'd0};
			3'd2:    shifted = {full[11:0], 12'd0};
			3'd3:    shifted = {full[17:0], 6'd0};
			default: shifted = full;
		endcase
		if (pos <= 3'd2)
			pads_d = {1'b0, padn} + 3'd2;
		else if (pos == 3'd3)
			pads_d = {1'b0, padn} + 3'd1;
		else
			pads_d = {1'b0, padn};

		dec_b.values[0] = shifted[23:16];
		dec_b.values[1] = shifted[15:8];
		dec_b.values[2] = shifted[7:0];
		dec_b.values[3] = 8'h00;
		dec_b.cnt  = (!done || pos < 3'd2) ? 3'd0 : 3'd3 - pads_d;
		dec_b.last = last_s1;
	end

	always_comb begin
		if (dir_q == DIR_DECODE) begin
			burst = dec_b;
			if (done) begin
				acc_d = '0; pbc_d = '0; gp_d = '0; pad_d = '0;
			end else begin
				acc_d = full[17:0]; pbc_d = pbc_q; gp_d = pos[1:0]; pad_d = padn;
			end
		end else begin
			burst = enc_b;
			if (last_s1) begin
				acc_d = '0; pbc_d = '0; gp_d = '0; pad_d = '0;
			end else begin
				acc_d = {14'd0, rem}; pbc_d = e_pbc; gp_d = gpk; pad_d = pad_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
			acc_q <= '0;
			pbc_q <= '0;
			gp_q  <= '0;
			pad_q <= '0;
		end else if (cfg.valid) begin
			dir_q <= cfg.direction;
			acc_q <= '0;
			pbc_q <= '0;
			gp_q  <= '0;
			pad_q <= '0;
		end else if (load) begin
			acc_q <= acc_d;
			pbc_q <= pbc_d;
			gp_q  <= gp_d;
			pad_q <= pad_d;
		end
	end

endmodule

@@ src/b64_out_buf.sv @@
module b64_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  b64_pkg::b64_burst_t burst,
	output logic                buf_free,
	b64_out_if.source           out_ch
);
	import b64_pkg::*;

	logic [SLOTS-1:0][7:0] values_s2;
	logic [2:0]            cnt_s2;
	logic                  last_s2;
	logic [2:0]            idx_q;
	logic                  busy_q;
	logic                  take;
	logic                  final_take;
	logic                  at_end;

	assign at_end     = (idx_q == cnt_s2 - 3'd1);
	assign take       = busy_q && out_ch.ready;
	assign final_take = take && at_end;
	assign buf_free   = !busy_q || final_take;

	assign out_ch.valid     = busy_q;
	assign out_ch.out_value = values_s2[idx_q[1:0]];
	assign out_ch.out_last  = last_s2 && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= (burst.cnt != 3'd0);
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
			if (at_end)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			values_s2 <= burst.values;
			cnt_s2    <= burst.cnt;
			last_s2   <= burst.last;
		end
	end

endmodule

@@ src/base64_codec.sv @@
// base64_codec: streaming base64 encoder/decoder (A-Z a-z 0-9 + /, '=' pad).
// Channels: in_ch (bytes or characters, in_last ends a message), out_ch
// (characters or bytes, out_last on the final result), cfg (direction,
// 0 encode, 1 decode). A cfg transfer also clears the stream state; write it
// only while the codec is idle. cfg.ready is always high.
// An accepted item is registered in the input register, expanded to its
// results and loaded into the output buffer, which offers them on out_ch.
// Throughput: one item per cycle into the input register while the output
// buffer is free; results leave one per cycle through the output buffer
// while out_ch.ready is high; the rate is set by the results per item:
// encode about 1.33 per byte, up to 4 at the last byte; decode up to 3
// at a group end, none for most characters, which leave the buffer free.
// Stall: when out_ch.ready is low the buffer holds its results, the input
// register fills and then in_ch.ready drops; nothing is lost or repeated.
// Reset (arst_n low): direction returns to encode, stream state and both
// registers empty.
module base64_codec (
	input  logic       clk,
	input  logic       arst_n,
	b64_in_if.sink     in_ch,
	b64_out_if.source  out_ch,
	b64_cfg_if.sink    cfg
);
	import b64_pkg::*;

	b64_burst_t burst;
	logic       load;
	logic       buf_free;

	// input register, stream state and per-item result expansion
	b64_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.buf_free (buf_free),
		.load     (load),
		.burst    (burst)
	);

	// result register, one transfer per cycle toward out_ch while out_ch.ready is high
	b64_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.buf_free (buf_free),
		.out_ch   (out_ch)
	);

endmodule

@@ sim/base64_codec_checker.sv @@
`timescale 1ns / 100ps

// Watches the three channels of the codec, keeps its own copy of the stream
// state and compares every output transfer with the oldest expected result.
module base64_codec_checker (
	input  logic clk,
	input  logic arst_n,
	b64_in_if    in_ch,
	b64_out_if   out_ch,
	b64_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen
);
	import b64_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} codec_out_t;

	// sextet value -> character, entry 0 is 'A'
	localparam logic [0:63][7:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic        dir;
	logic [17:0] acc;		// encode: leftover bits, decode: sextets of the group
	logic [1:0]  half_bits;	// leftover encode bits / 2
	logic [1:0]  grp_pos;
	logic [1:0]  pad_seen;	// '=' in third or fourth place
	codec_out_t  due_out[$];

	// reverse lookup; pad and foreign characters give zero
	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [5:0] v;
		v = '0;
		for (int k = 0; k < 64; k++)
			if (ALPHABET[k] == c)
				v = 6'(k);
		return v;
	endfunction

	task automatic clear_stream();
		acc = '0;
		half_bits = '0;
		grp_pos = '0;
		pad_seen = '0;
	endtask

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic fin);
		codec_out_t  res[4];
		logic [11:0] x;
		int          n;
		int          bits;
		n = 0;
		x = {acc[3:0], b};
		bits = int'(half_bits) * 2 + 8;
		while (bits >= 6) begin
			bits -= 6;
			res[n] = codec_out_t'{ALPHABET[6'(x >> bits)], 1'b0};
			n++;
			grp_pos++;
		end
		acc = 18'(x & ((12'd1 << bits) - 12'd1));
		half_bits = 2'(bits / 2);
		if (fin) begin
			// flush leftover bits, zero filled, then pad to a full group
			if (bits > 0) begin
				res[n] = codec_out_t'{ALPHABET[6'(acc << (6 - bits))], 1'b0};
				n++;
				grp_pos++;
			end
			while (grp_pos != 2'd0) begin
				res[n] = codec_out_t'{CHAR_PAD, 1'b0};
				n++;
				grp_pos++;
			end
			res[n - 1].last = 1'b1;
			clear_stream();
		end
		for (int i = 0; i < n; i++)
			due_out.push_back(res[i]);
	endtask

	task automatic decode_char(input logic [7:0] c, input logic fin);
		logic [23:0] word;
		int          pos;
		int          missing;
		int          nbytes;
		pos = int'(grp_pos);
		if (pos >= 2 && c == CHAR_PAD)
			pad_seen++;
		word = {acc, sextet_of(c)};
		pos++;
		if (pos < 4 && !fin) begin
			acc = word[17:0];
			grp_pos = 2'(pos);
		end else begin
			// a short final group counts its missing places as pads
			word = word << (6 * (4 - pos));
			missing = int'(pad_seen) + 4 - (pos > 2 ? pos : 2);
			nbytes = (pos < 2) ? 0 : 3 - missing;
			for (int i = 0; i < nbytes; i++)
				due_out.push_back(codec_out_t'{word[23 - 8 * i -: 8], fin && (i == nbytes - 1)});
			clear_stream();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		codec_out_t want;
		if (!arst_n) begin
			dir = DIR_ENCODE;
			clear_stream();
			due_out.delete();
			mismatches = 0;
			results_seen = 0;
			outstanding = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (due_out.size() == 0) begin
					report("unexpected result", out_ch.out_value, 8'hxx);
				end else begin
					want = due_out.pop_front();
					if (out_ch.out_value !== want.value)
						report("out_value", out_ch.out_value, want.value);
					if (out_ch.out_last !== want.last)
						report("out_last", 8'(out_ch.out_last), 8'(want.last));
				end
			end
			if (cfg.valid && cfg.ready) begin
				dir = cfg.direction;
				clear_stream();
			end
			if (in_ch.valid && in_ch.ready) begin
				if (dir == DIR_ENCODE)
					encode_byte(in_ch.in_value, in_ch.in_last);
				else
					decode_char(in_ch.in_value, in_ch.in_last);
			end
			outstanding = due_out.size();
		end
	end

endmodule

@@ sim/base64_codec_test.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the base64 codec. Checking lives in
// base64_codec_checker, which sits beside the block on the same channels.
module base64_codec_test;
	import b64_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;	// cycles without any transfer
	localparam int RANDOM_ITEMS   = 80;
	localparam int HOLD_OFF       = 6;		// covers the input and burst registers

	logic clk;
	logic arst_n;

	b64_in_if  in_ch();
	b64_out_if out_ch();
	b64_cfg_if cfg();

	int mismatches;
	int outstanding;
	int results_seen;
	int items_sent;
	int cfg_writes;
	int idle_cycles;
	bit calm;		// set for the last part of the run: no idling on either side

	base64_codec uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	base64_codec_checker codec_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.cfg          (cfg),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Raw byte: extremes now and then, otherwise anything.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// One character of the alphabet, each class about equally often.
	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(0, 3))
			0:       return 8'h41 + 8'($urandom_range(0, 25));	// A-Z
			1:       return 8'h61 + 8'($urandom_range(0, 25));	// a-z
			2:       return 8'h30 + 8'($urandom_range(0, 9));	// 0-9
			default: return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_SLASH;
		endcase
	endfunction

	// One input transfer. Called at a falling edge, returns at a falling edge
	// with valid still high, so back-to-back items keep valid asserted.
	task automatic push_item(input logic [7:0] v, input logic fin);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.in_value <= v;
		in_ch.in_last  <= fin;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic push_text(input string s, input logic fin);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], fin && (i == s.len() - 1));
	endtask

	// Drop valid, let every expected result drain, then wait out HOLD_OFF as
	// well: an item with no result may still be in flight.
	task automatic close_phase();
		in_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (HOLD_OFF) @(negedge clk);
	endtask

	// Only called with the codec idle; the write also clears the stream state.
	task automatic set_direction(input logic d);
		cfg.valid     <= 1'b1;
		cfg.direction <= d;
		do @(posedge clk); while (!cfg.ready);
		cfg_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Result side: ready drops now and then, and goes high again before each
	// new drop. No new drops begin once the run turns calm.
	initial begin
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else if (!calm && out_ch.ready && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				hold = $urandom_range(1, 13) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: any transfer on any channel restarts the count.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transfer for %0d cycles, %0d results still due",
			WATCHDOG_LIMIT, outstanding);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [7:0] ch;
		int         n_groups;
		int         n_pads;
		int         len;
		int         rand_base;
		bit         enc_next;

		items_sent     = 0;
		cfg_writes     = 0;
		calm           = 1'b0;
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.in_value = 8'h00;
		in_ch.in_last  = 1'b0;
		cfg.valid      = 1'b0;
		cfg.direction  = DIR_ENCODE;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed, encode (the reset direction) ----
		// An open message: 'T' comes out, two bits stay behind. The register
		// write that follows must throw them away.
		push_item(8'h4D, 1'b0);
		close_phase();
		set_direction(DIR_ENCODE);
		// one byte -> two pads; two bytes -> one pad, and '/' twice
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b1);
		// three bytes -> four '+' and no pad
		push_item(8'hFB, 1'b0);
		push_item(8'hEF, 1'b0);
		push_item(8'hBE, 1'b1);
		close_phase();

		// ---- directed, decode ----
		// Half a group left open, then cleared by writing the same direction.
		set_direction(DIR_DECODE);
		push_text("TW", 1'b0);
		close_phase();
		set_direction(DIR_DECODE);
		push_text("TQ==", 1'b0);	// two pads at the end: one byte
		push_text("=B=C", 1'b0);	// early pad is just zero; pad then character
		// characters outside the alphabet decode as zero; '+' and '/' at the top
		push_item(8'hFF, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(CHAR_PLUS, 1'b0);
		push_item(CHAR_SLASH, 1'b1);
		// short final groups: three, one (no byte, no last) and two characters
		push_text("QUI", 1'b1);
		push_text("Q", 1'b1);
		push_text("QQ", 1'b1);
		close_phase();

		// ---- random phases, alternating direction ----
		rand_base = items_sent;
		enc_next = 1'b1;
		while (items_sent - rand_base < RANDOM_ITEMS) begin
			if (items_sent - rand_base >= RANDOM_ITEMS * 3 / 4)
				calm = 1'b1;
			set_direction(enc_next ? DIR_ENCODE : DIR_DECODE);
			repeat ($urandom_range(3, 6)) begin
				if (enc_next) begin
					len = $urandom_range(1, 7);
					for (int i = 0; i < len; i++)
						push_item(pick_byte(), i == len - 1);
				end else if ($urandom_range(0, 5) != 0) begin
					// well formed: whole groups, pads only at the very end
					n_groups = $urandom_range(1, 3);
					n_pads = $urandom_range(0, 2);
					for (int g = 0; g < n_groups; g++)
						for (int p = 0; p < 4; p++) begin
							ch = (g == n_groups - 1 && p >= 4 - n_pads) ? CHAR_PAD :
								pick_symbol();
							push_item(ch, g == n_groups - 1 && p == 3);
						end
				end else begin
					// noise: any byte, stray pads, lengths 1 to 9
					len = $urandom_range(1, 9);
					for (int i = 0; i < len; i++) begin
						case ($urandom_range(0, 5))
							0, 1:    ch = 8'($urandom);
							2:       ch = CHAR_PAD;
							default: ch = pick_symbol();
						endcase
						push_item(ch, i == len - 1);
					end
				end
			end
			// now and then leave a message open for the next write to clear
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					push_item(enc_next ? pick_byte() : pick_symbol(), 1'b0);
			close_phase();
			enc_next = !enc_next;
		end

		$display("covered %0d input transfers under %0d direction writes, %0d results checked",
			items_sent, cfg_writes, results_seen);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
src/b64_pkg.sv
src/b64_ifs.sv
src/b64_core.sv
src/b64_out_buf.sv
src/base64_codec.sv
sim/base64_codec_checker.sv
sim/base64_codec_test.sv
